>>> rtl/mbst_pkg.sv
// shared constants, types and the alpha table for the meter ballistics block
`default_nettype none
package mbst_pkg;

  localparam int SLOT_COUNT  = 1024;
  localparam int SLOT_AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FILL_W      = $clog2(SLOT_COUNT + 1);

  localparam int HANDLE_W    = 16;
  localparam int CHAN_W      = 4;
  localparam int KEY_W       = HANDLE_W + CHAN_W + 1;
  localparam int LEVEL_W     = 16;
  localparam int TARGET_W    = 17;
  localparam int TIME_W      = 40;
  localparam int TAU_W       = 16;
  localparam int STALE_W     = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int ENTRY_W     = KEY_W + LEVEL_W + TIME_W;
  localparam int PROD_W      = 2 * LEVEL_W;

  localparam int ALPHA_DEPTH   = 256;
  localparam int ALPHA_X_RANGE = 8;
  localparam int ALPHA_IW      = $clog2(ALPHA_DEPTH);
  localparam int STEP_W        = $clog2(ALPHA_IW);
  localparam int DIV_W         = TAU_W + $clog2(ALPHA_X_RANGE);
  localparam int NUM_W         = TIME_W + ALPHA_IW + 1;
  localparam int REM_W         = DIV_W + ALPHA_IW + 1;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(32768);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_STALE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TAU_W-1:0]   attack_tau;
    logic [TAU_W-1:0]   release_tau;
    logic [STALE_W-1:0] stale_after;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
    logic div_step;
    logic look;
    logic mul;
    logic upd;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic direct;
    logic sat;
    logic div_done;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV,
    ST_LOOK,
    ST_MUL,
    ST_UPD,
    ST_WRITE
  } state_t;

  typedef logic [LEVEL_W-1:0] alpha_tab_t [ALPHA_DEPTH];

  // exp(-h) by taylor series in q31, then repeated powers give 1 - exp(-x)
  function automatic alpha_tab_t build_alpha();
    logic [63:0] hq;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] cur;
    alpha_tab_t  t;
    hq   = (64'(ALPHA_X_RANGE) << 31) / 64'(ALPHA_DEPTH);
    term = 64'd1 << 31;
    pos  = term;
    neg  = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * hq) >> 31) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    e   = (pos > neg) ? pos - neg : 64'd0;
    cur = 64'd1 << 31;
    for (int i = 0; i < ALPHA_DEPTH; i++) begin
      t[i] = LEVEL_W'(64'(FULL_SCALE) - ((cur + 64'd32768) >> 16));
      cur  = (cur * e + (64'd1 << 30)) >> 31;
    end
    return t;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_alpha();

endpackage
`default_nettype wire

>>> rtl/mbst_in_if.sv
// input channel: one level reading per beat
`default_nettype none
interface mbst_in_if;
  import mbst_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [HANDLE_W-1:0]        stream_handle;
  logic [CHAN_W-1:0]          channel_number;
  logic                       is_capture;
  logic signed [TARGET_W-1:0] target_level;
  logic [TIME_W-1:0]          now_ms;

  modport source (output valid, stream_handle, channel_number, is_capture, target_level,
                  now_ms, input ready);
  modport sink (input valid, stream_handle, channel_number, is_capture, target_level,
                now_ms, output ready);
endinterface
`default_nettype wire

>>> rtl/mbst_out_if.sv
// result channel: one smoothed level per beat
`default_nettype none
interface mbst_out_if;
  import mbst_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] smoothed_level;
  logic               slot_hit;

  modport source (output valid, smoothed_level, slot_hit, input ready);
  modport sink (input valid, smoothed_level, slot_hit, output ready);
endinterface
`default_nettype wire

>>> rtl/meter_ballistics_slot_table.sv
// top level: config registers, sequencer and datapath of the level meter ballistics
// One result beat per input beat. With N slots filled (at most 1024), the scan reads at
// most N entries. A miss or snapped hit goes straight to write back, a smoothed hit
// whose alpha index runs past the table end skips divider and lookup, and any other
// smoothed hit takes every step; write back waits while the previous result is still
// waiting. The slot memory is read one entry per cycle while the key is searched and
// the free, stale and least recent candidates are tracked, and a match ends the search
// early. The alpha index is divided out one quotient bit per cycle. Occupied slots are
// kept by a fill count, so there is no clearing pass after reset. A finished result waits
// in the output register; the next item is taken once the current one is written back.
`default_nettype none
module meter_ballistics_slot_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mbst_in_if.sink                             in_ch,
  mbst_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [mbst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbst_pkg::CFG_W-1:0]     cfg_wdata
);
  import mbst_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_tau  <= TAU_W'(45);
      cfg_r.release_tau <= TAU_W'(180);
      cfg_r.stale_after <= STALE_W'(3000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  cfg_r.attack_tau  <= cfg_wdata[TAU_W-1:0];
        CFG_RELEASE: cfg_r.release_tau <= cfg_wdata[TAU_W-1:0];
        CFG_STALE:   cfg_r.stale_after <= cfg_wdata[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  mbst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbst_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg                (cfg_r),
    .in_stream_handle   (in_ch.stream_handle),
    .in_channel_number  (in_ch.channel_number),
    .in_is_capture      (in_ch.is_capture),
    .in_target_level    (in_ch.target_level),
    .in_now_ms          (in_ch.now_ms),
    .out_smoothed_level (out_ch.smoothed_level),
    .out_slot_hit       (out_ch.slot_hit)
  );

  // busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again right after accept");

  // a write back always presents a result
  a_write_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> out_ch.valid)
    else $error("write back without result beat");

  // only one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.scan, cmd.decide, cmd.div_step, cmd.look, cmd.mul,
              cmd.upd, cmd.write}))
    else $error("overlapping datapath commands");

  // the sequencer only starts on a real beat
  a_start_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (in_ch.valid && in_ch.ready))
    else $error("start without input beat");
endmodule
`default_nettype wire

>>> rtl/mbst_ctrl.sv
// sequencer: scan, decide, divide, lookup, multiply, update, write back
`default_nettype none
module mbst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  input  wire mbst_pkg::stat_t stat,
  output mbst_pkg::cmd_t       cmd
);
  import mbst_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.direct)   state_nxt = ST_WRITE;
        else if (stat.sat) state_nxt = ST_MUL;
        else               state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.write     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/mbst_dp.sv
// datapath: slot memory, scan trackers, alpha divider, smoothing arithmetic
`default_nettype none
module mbst_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mbst_pkg::cmd_t                      cmd,
  output mbst_pkg::stat_t                          stat,
  input  wire mbst_pkg::cfg_t                      cfg,
  input  wire logic [mbst_pkg::HANDLE_W-1:0]       in_stream_handle,
  input  wire logic [mbst_pkg::CHAN_W-1:0]         in_channel_number,
  input  wire logic                                in_is_capture,
  input  wire logic signed [mbst_pkg::TARGET_W-1:0] in_target_level,
  input  wire logic [mbst_pkg::TIME_W-1:0]         in_now_ms,
  output logic [mbst_pkg::LEVEL_W-1:0]             out_smoothed_level,
  output logic                                     out_slot_hit
);
  import mbst_pkg::*;

  logic [ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [ENTRY_W-1:0] mem_q_r;

  logic [KEY_W-1:0]   key_r;
  logic [LEVEL_W-1:0] target_r;
  logic [TIME_W-1:0]  now_r;
  logic [FILL_W-1:0]  fill_r, addr_r;
  logic               pend_r;
  logic [SLOT_AW-1:0] rd_idx_r;
  logic               hit_r;
  logic [SLOT_AW-1:0] hit_idx_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [TIME_W-1:0]  last_r;
  logic               stale_have_r, lru_have_r;
  logic [SLOT_AW-1:0] stale_idx_r, lru_idx_r, sel_r;
  logic [TIME_W-1:0]  lru_t_r;
  logic               up_r;
  logic [LEVEL_W-1:0] diff_r;
  logic [DIV_W-1:0]   dd_r;
  logic [REM_W-1:0]   rem_r;
  logic [ALPHA_IW-1:0] q_r;
  logic [STEP_W-1:0]  step_r;
  logic [LEVEL_W-1:0] alpha_r;
  logic [PROD_W-1:0]  prod_r;
  logic [LEVEL_W-1:0] res_lvl_r;
  logic               res_hit_r;

  // combinational helpers
  logic [LEVEL_W-1:0] clamp_tgt;
  logic               issue;
  logic [KEY_W-1:0]   e_key;
  logic [TIME_W-1:0]  e_last;
  logic [LEVEL_W-1:0] e_lvl;
  logic [TIME_W-1:0]  e_age;
  logic               snap, up;
  logic [TAU_W-1:0]   tau;
  logic [DIV_W-1:0]   dd;
  logic [TIME_W-1:0]  dt;
  logic [NUM_W-1:0]   num;
  logic               sat;
  logic               free_ok;
  logic [REM_W-1:0]   trial;
  logic [PROD_W-1:0]  inc;
  logic [LEVEL_W:0]   sum;

  assign clamp_tgt = in_target_level[TARGET_W-1] ? '0 :
                     (in_target_level[LEVEL_W-1:0] > FULL_SCALE) ? FULL_SCALE :
                     in_target_level[LEVEL_W-1:0];

  assign issue = cmd.scan && !hit_r && (addr_r < fill_r);
  assign {e_key, e_lvl, e_last} = mem_q_r;
  assign e_age = now_r - e_last;

  assign snap    = now_r <= last_r;
  assign up      = target_r >= lvl_r;
  assign tau     = (up ? cfg.attack_tau : cfg.release_tau) == '0 ? TAU_W'(1) :
                   (up ? cfg.attack_tau : cfg.release_tau);
  assign dd      = DIV_W'(tau) * DIV_W'(ALPHA_X_RANGE);
  assign dt      = now_r - last_r;
  assign num     = NUM_W'(dt) * NUM_W'(ALPHA_DEPTH)
                 + NUM_W'(tau) * NUM_W'(ALPHA_X_RANGE / 2);
  assign sat     = num >= NUM_W'(dd) * NUM_W'(ALPHA_DEPTH);
  assign free_ok = fill_r < FILL_W'(SLOT_COUNT);

  assign trial = REM_W'(dd_r) << step_r;
  assign inc   = (prod_r + ROUND_HALF) >> 15;
  assign sum   = (LEVEL_W + 1)'(lvl_r) + (LEVEL_W + 1)'(inc);

  assign stat.scan_done = hit_r || (!(addr_r < fill_r) && !pend_r);
  assign stat.direct    = !hit_r || snap;
  assign stat.sat       = sat;
  assign stat.div_done  = (step_r == '0);

  assign out_smoothed_level = res_lvl_r;
  assign out_slot_hit       = res_hit_r;

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.write) mem[sel_r] <= {key_r, lvl_r, now_r};
    mem_q_r <= mem[addr_r[SLOT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.start) pend_r <= 1'b0;
      else           pend_r <= issue;
      if (cmd.decide && !hit_r && free_ok) fill_r <= fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r        <= {in_is_capture, in_channel_number, in_stream_handle};
      target_r     <= clamp_tgt;
      now_r        <= in_now_ms;
      addr_r       <= '0;
      hit_r        <= 1'b0;
      stale_have_r <= 1'b0;
      lru_have_r   <= 1'b0;
    end
    if (issue) begin
      addr_r   <= addr_r + FILL_W'(1);
      rd_idx_r <= addr_r[SLOT_AW-1:0];
    end
    // entry read last cycle is examined now
    if (cmd.scan && pend_r && !hit_r) begin
      if (e_key == key_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
        lvl_r     <= e_lvl;
        last_r    <= e_last;
      end else begin
        if (!stale_have_r && (e_age > TIME_W'(cfg.stale_after))) begin
          stale_have_r <= 1'b1;
          stale_idx_r  <= rd_idx_r;
        end
        if (!lru_have_r || (e_last < lru_t_r)) begin
          lru_have_r <= 1'b1;
          lru_idx_r  <= rd_idx_r;
          lru_t_r    <= e_last;
        end
      end
    end
    if (cmd.decide) begin
      up_r    <= up;
      diff_r  <= up ? target_r - lvl_r : lvl_r - target_r;
      dd_r    <= dd;
      rem_r   <= num[REM_W-1:0];
      q_r     <= '0;
      step_r  <= STEP_W'(ALPHA_IW - 1);
      alpha_r <= FULL_SCALE;
      if (hit_r) begin
        sel_r <= hit_idx_r;
        if (snap) lvl_r <= target_r;
      end else begin
        lvl_r <= target_r;
        if (free_ok)           sel_r <= fill_r[SLOT_AW-1:0];
        else if (stale_have_r) sel_r <= stale_idx_r;
        else                   sel_r <= lru_idx_r;
      end
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      if (rem_r >= trial) begin
        rem_r       <= rem_r - trial;
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.look) alpha_r <= ALPHA_TAB[q_r];
    if (cmd.mul)  prod_r  <= PROD_W'(diff_r) * PROD_W'(alpha_r);
    if (cmd.upd) begin
      if (up_r) begin
        lvl_r <= (sum > (LEVEL_W + 1)'(FULL_SCALE)) ? FULL_SCALE : sum[LEVEL_W-1:0];
      end else begin
        lvl_r <= (inc > PROD_W'(lvl_r)) ? '0 : lvl_r - inc[LEVEL_W-1:0];
      end
    end
    if (cmd.write) begin
      res_lvl_r <= lvl_r;
      res_hit_r <= hit_r;
    end
  end
endmodule
`default_nettype wire

>>> bench/mbst_level_checker.sv
// checker for the meter ballistics block: tracks config, predicts each result, compares beats
`default_nettype none
module mbst_level_checker
  import mbst_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  mbst_in_if                        in_ch,
  mbst_out_if                       out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output int                        mismatches,
  output int                        levels_pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               hit;
  } level_result_t;

  level_result_t level_q[$];

  logic [TAU_W-1:0]   attack_tau;
  logic [TAU_W-1:0]   release_tau;
  logic [STALE_W-1:0] stale_after;

  logic               slot_used [SLOT_COUNT];
  logic [KEY_W-1:0]   slot_id   [SLOT_COUNT];
  logic [LEVEL_W-1:0] slot_lvl  [SLOT_COUNT];
  logic [TIME_W-1:0]  slot_seen [SLOT_COUNT];

  logic [LEVEL_W-1:0] gain_tab [ALPHA_DEPTH];

  // q31 exp(-h) by series, then successive powers give 1 - exp(-x) in q15
  initial begin
    logic [63:0] h, t, p, n, ex, c;
    h = (64'd8 << 31) / 64'(ALPHA_DEPTH);
    t = 64'd1 << 31;
    p = t;
    n = 0;
    for (int k = 1; k <= 24; k++) begin
      t = ((t * h) >> 31) / 64'(k);
      if (k[0]) n = n + t;
      else p = p + t;
    end
    ex = (p > n) ? p - n : 64'd0;
    c = 64'd1 << 31;
    for (int i = 0; i < ALPHA_DEPTH; i++) begin
      gain_tab[i] = LEVEL_W'(64'd32768 - ((c + 64'd32768) >> 16));
      c = (c * ex + (64'd1 << 30)) >> 31;
    end
  end

  function automatic logic [LEVEL_W-1:0] gain_for(logic [TIME_W-1:0] dt, logic [TAU_W-1:0] tau);
    logic [63:0] t;
    logic [63:0] idx;
    t = (tau == 0) ? 64'd1 : 64'(tau);
    idx = (64'(dt) * 64'(ALPHA_DEPTH) + 4 * t) / (8 * t);
    if (idx >= 64'(ALPHA_DEPTH)) return FULL_SCALE;
    return gain_tab[idx[ALPHA_IW-1:0]];
  endfunction

  function automatic logic [16:0] scaled_step(logic [16:0] diff, logic [LEVEL_W-1:0] g);
    return 17'((64'(diff) * 64'(g) + 64'd16384) >> 15);
  endfunction

  task automatic smooth_reading(input logic [KEY_W-1:0] k, input logic [TARGET_W-1:0] raw,
                                input logic [TIME_W-1:0] now);
    logic [16:0]       tgt;
    logic [16:0]       lv;
    logic [16:0]       d;
    logic [TIME_W-1:0] lru_t;
    int                hit_i, free_i, stale_i, lru_i, sel;
    level_result_t     r;
    hit_i = -1; free_i = -1; stale_i = -1; lru_i = -1;
    lru_t = 0;
    if (raw[TARGET_W-1]) tgt = 0;
    else tgt = (raw > 17'd32768) ? 17'd32768 : raw;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!slot_used[i]) begin
        if (free_i < 0) free_i = i;
        continue;
      end
      if (slot_id[i] == k) begin
        hit_i = i;
        break;
      end
      if (stale_i < 0 && TIME_W'(now - slot_seen[i]) > 40'(stale_after)) stale_i = i;
      if (lru_i < 0 || slot_seen[i] < lru_t) begin
        lru_i = i;
        lru_t = slot_seen[i];
      end
    end
    if (hit_i >= 0) begin
      sel = hit_i;
      lv = 17'(slot_lvl[sel]);
      if (now <= slot_seen[sel]) begin
        lv = tgt;
      end else if (tgt >= lv) begin
        lv = lv + scaled_step(tgt - lv, gain_for(now - slot_seen[sel], attack_tau));
      end else begin
        d = scaled_step(lv - tgt, gain_for(now - slot_seen[sel], release_tau));
        lv = (d > lv) ? 17'd0 : lv - d;
      end
      if (lv > 17'd32768) lv = 17'd32768;
    end else begin
      sel = (free_i >= 0) ? free_i : ((stale_i >= 0) ? stale_i : lru_i);
      if (sel < 0) sel = 0;
      slot_used[sel] = 1'b1;
      slot_id[sel] = k;
      lv = tgt;
    end
    slot_lvl[sel] = LEVEL_W'(lv);
    slot_seen[sel] = now;
    r.level = LEVEL_W'(lv);
    r.hit = (hit_i >= 0);
    level_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  assign levels_pending = level_q.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    level_result_t w;
    if (!rst_n) begin
      attack_tau  <= TAU_W'(45);
      release_tau <= TAU_W'(180);
      stale_after <= STALE_W'(3000);
      for (int i = 0; i < SLOT_COUNT; i++) slot_used[i] = 1'b0;
      level_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK:  attack_tau  <= cfg_wdata[TAU_W-1:0];
          CFG_RELEASE: release_tau <= cfg_wdata[TAU_W-1:0];
          CFG_STALE:   stale_after <= cfg_wdata[STALE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        smooth_reading({in_ch.is_capture, in_ch.channel_number, in_ch.stream_handle},
                       in_ch.target_level, in_ch.now_ms);
      if (out_ch.valid && out_ch.ready) begin
        if (level_q.size() == 0) begin
          report("unexpected beat", out_ch.smoothed_level, 0);
        end else begin
          w = level_q.pop_front();
          if (out_ch.smoothed_level !== w.level)
            report("smoothed_level", out_ch.smoothed_level, w.level);
          if (out_ch.slot_hit !== w.hit)
            report("slot_hit", out_ch.slot_hit, w.hit);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> bench/tb_meter_ballistics_slot_table.sv
// testbench top: clock, reset, stimulus, back-pressure and verdict for the meter block
`default_nettype none
module tb_meter_ballistics_slot_table;
  import mbst_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int mismatches;
  int levels_pending;
  int idle_cycles;
  int burst_left;
  logic [TIME_W-1:0] clock_ms;
  logic [KEY_W-1:0] key_pool [12];

  logic [1:0] stall_mode;
  logic [31:0] stall_pat;
  int stall_cnt;
  logic [4:0] stall_phase;

  mbst_in_if  in_ch();
  mbst_out_if out_ch();

  meter_ballistics_slot_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mbst_level_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .levels_pending(levels_pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stalls: modes change every so often, mode 0 never stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= 0;
      stall_mode <= 0;
      stall_pat <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 5'd1;
      if (stall_cnt == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        stall_pat <= $urandom;
        stall_cnt <= $urandom_range(16, 200);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      out_ch.ready <= (stall_mode == 0) || stall_pat[stall_phase];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_reading(input logic [KEY_W-1:0] k, input logic [TARGET_W-1:0] lvl,
                              input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.stream_handle <= k[HANDLE_W-1:0];
    in_ch.channel_number <= k[HANDLE_W +: CHAN_W];
    in_ch.is_capture <= k[KEY_W-1];
    in_ch.target_level <= lvl;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    burst_left--;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (levels_pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TARGET_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 17'($urandom);
      1: return 17'h10000 | 17'($urandom_range(0, 65535));
      2: return 17'($urandom_range(32769, 65535));
      3: return 17'd32768;
      4: return 17'd0;
      default: return 17'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic random_reading(input bit full_table);
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 19))
      0: clock_ms = clock_ms;
      1: clock_ms = clock_ms - TIME_W'($urandom_range(1, 50));
      2: clock_ms = {8'($urandom), $urandom};
      3: clock_ms = clock_ms + TIME_W'($urandom_range(1000, 200000));
      default: clock_ms = clock_ms + TIME_W'($urandom_range(1, 400));
    endcase
    if ($urandom_range(0, 99) < 85) begin
      k = key_pool[$urandom_range(0, 11)];
    end else begin
      k = 21'($urandom);
      if (full_table && $urandom_range(0, 1)) k = {5'($urandom), 1'b1, 15'($urandom)};
    end
    send_reading(k, pick_level(), clock_ms);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    burst_left = 0;
    in_ch.valid = 0;
    in_ch.stream_handle = 0;
    in_ch.channel_number = 0;
    in_ch.is_capture = 0;
    in_ch.target_level = 0;
    in_ch.now_ms = 0;
    key_pool[0] = 21'h000000;
    key_pool[1] = {1'b1, 4'hf, 16'hffff};
    key_pool[2] = {1'b0, 4'hf, 16'h0000};
    key_pool[3] = {1'b1, 4'h0, 16'hffff};
    for (int i = 4; i < 12; i++) key_pool[i] = {5'($urandom), 1'b0, 15'($urandom)};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: claims, rising and falling hits, stalled and reversed time, clamps
    send_reading(key_pool[0], 17'd1000, 40'd10);
    send_reading(key_pool[0], 17'd30000, 40'd20);
    send_reading(key_pool[0], 17'd0, 40'd200);
    send_reading(key_pool[0], 17'd5000, 40'd200);
    send_reading(key_pool[0], 17'd9000, 40'd150);
    send_reading(key_pool[1], 17'h1ffff, 40'd300);
    send_reading(key_pool[1], 17'd65535, 40'd301);
    send_reading(key_pool[1], 17'h10000, 40'd302);
    send_reading(key_pool[2], 17'd32768, 40'd400);
    send_reading(key_pool[2], 17'd32767, 40'd100000);
    send_reading(key_pool[2], 17'd1, 40'd100001);
    send_reading(key_pool[3], 17'd16384, 40'hff_ffff_fff0);
    send_reading(key_pool[3], 17'd20000, 40'hff_ffff_ffff);
    send_reading(key_pool[3], 17'd0, 40'd5);
    send_reading(key_pool[0], 17'd32768, 40'd230);
    send_reading(key_pool[0], 17'd12000, 40'd260);
    settle();

    write_reg(CFG_ATTACK, 32'd1);
    write_reg(CFG_RELEASE, 32'hffff_ffff);
    write_reg(CFG_STALE, 32'd0);
    write_reg(CFG_UNUSED, 32'h0000_0001);
    clock_ms = 40'd1000;
    for (int i = 0; i < 100; i++) random_reading(1'b0);
    settle();

    write_reg(CFG_ATTACK, 32'hffff_0000);
    write_reg(CFG_RELEASE, 32'd1);
    write_reg(CFG_STALE, 32'hffff_ffff);
    for (int i = 0; i < 100; i++) random_reading(1'b0);
    settle();

    // spread fresh keys over many more slots so the search runs long
    write_reg(CFG_ATTACK, 32'd45);
    write_reg(CFG_RELEASE, 32'd180);
    for (int i = 0; i < 200; i++) begin
      clock_ms = clock_ms + 1;
      send_reading({5'($urandom), 1'b1, 15'(i)}, pick_level(), clock_ms);
    end
    for (int i = 0; i < 60; i++) random_reading(1'b1);
    settle();

    write_reg(CFG_STALE, 32'd50);
    for (int i = 0; i < 60; i++) random_reading(1'b1);
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
